>>> sv/fcmv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fcmv_pkg;

    localparam int COUNT_BINS = 16;
    localparam int BIN_W      = $clog2(COUNT_BINS);
    localparam int BIN_POW    = 1 << BIN_W;

    localparam int HIST_W     = 7;
    localparam int IDLE_W     = 8;
    localparam int ROWS_W     = 12;
    localparam int WIN_W      = 7;
    localparam int COUNT_W    = 4;
    localparam int HEIGHT_W   = 12;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [HIST_W-1:0] HIST_MAX = {HIST_W{1'b1}};
    localparam logic [IDLE_W-1:0] IDLE_MAX = {IDLE_W{1'b1}};

    localparam logic [ROWS_W-1:0] ROWS_RESET     = ROWS_W'(480);
    localparam logic [IDLE_W-1:0] IDLE_THR_RESET = IDLE_W'(12);
    localparam logic [WIN_W-1:0]  WIN_RESET      = WIN_W'(14);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_ROWS     = 2'd0,
        CFG_IDLE_THRESHOLD = 2'd1,
        CFG_WINDOW_LENGTH  = 2'd2
    } t_cfg_idx;

endpackage

`default_nettype wire

>>> sv/finger_count_mode_vote_top.sv
// Finger count mode vote filter.
// Input channel (i_valid / o_stall): one transaction per video frame carrying
// finger count, box height and hand flag. A transaction is taken at a clock
// edge with i_valid high and o_stall low.
// Output channel (o_valid / i_stall): exactly one result per input frame,
// carrying decision_valid, decided_count and collecting.
// The result of a frame taken at an edge is registered at that edge and is on
// the outputs after it. Throughput is one frame per cycle while no result is
// stalled; the histogram update, qualification and mode tree all settle
// combinationally between the port inputs and the state / result registers.
// Configuration (i_cfg_valid / o_cfg_ready, always ready): index 0 image rows,
// 1 idle threshold, 2 window length; other indexes are ignored. Write only
// while no frame is in flight.
// Reset (synchronous, active low) restores the register defaults (480, 12,
// 14), clears the histogram, frame and idle counters and empties the output.
// When the receiver stalls a held result, the result register holds and o_stall
// rises, so no new frame is taken until the result leaves.
`timescale 1ns / 1ps
`default_nettype none

module finger_count_mode_vote_top
    import fcmv_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,

    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [COUNT_W-1:0]    i_finger_count,
    input  wire logic [HEIGHT_W-1:0]   i_box_height,
    input  wire logic                  i_hand_seen,

    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic                       o_decision_valid,
    output logic [COUNT_W-1:0]         o_decided_count,
    output logic                       o_collecting
);

    logic [ROWS_W-1:0] r_image_rows;
    logic [IDLE_W-1:0] r_idle_thr;
    logic [WIN_W-1:0]  r_win_len;

    logic [HIST_W-1:0] r_hist [COUNT_BINS];
    logic [HIST_W-1:0] n_hist [COUNT_BINS];
    logic [WIN_W-1:0]  r_collected;
    logic [WIN_W-1:0]  n_collected;
    logic [IDLE_W-1:0] r_idle;
    logic [IDLE_W-1:0] n_idle;

    logic               r_valid;
    logic               r_decision;
    logic [COUNT_W-1:0] r_decided;
    logic               r_collecting;

    logic             accept;
    logic             qualify;
    logic             decide;
    logic [BIN_W-1:0] bin;
    logic [BIN_W-1:0] mode_bin;

    logic [HIST_W-1:0] tr_f [BIN_W+1][BIN_POW];
    logic [BIN_W-1:0]  tr_i [BIN_W+1][BIN_POW];

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_valid & i_stall;
    assign accept      = i_valid & ~o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_rows <= ROWS_RESET;
            r_idle_thr   <= IDLE_THR_RESET;
            r_win_len    <= WIN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_IMAGE_ROWS:     r_image_rows <= ROWS_W'(i_cfg_data);
                CFG_IDLE_THRESHOLD: r_idle_thr   <= IDLE_W'(i_cfg_data);
                CFG_WINDOW_LENGTH:  r_win_len    <= WIN_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    assign qualify = (i_box_height > (r_image_rows >> 1))
                   && (r_idle > r_idle_thr) && i_hand_seen;

    always_comb begin
        if (int'(i_finger_count) < COUNT_BINS) begin
            bin = BIN_W'(i_finger_count);
        end else begin
            bin = BIN_W'(COUNT_BINS - 1);
        end
    end

    assign decide = qualify
                  && (({1'b0, r_collected} + (WIN_W+1)'(1)) >= {1'b0, r_win_len});

    always_comb begin
        for (int b = 0; b < COUNT_BINS; b++) begin
            n_hist[b] = r_hist[b];
            if (qualify && (bin == BIN_W'(b)) && (r_hist[b] != HIST_MAX)) begin
                n_hist[b] = r_hist[b] + HIST_W'(1);
            end
        end
    end

    // mode tree: right side wins only when strictly larger, so ties keep the lower bin
    always_comb begin
        for (int l = 0; l <= BIN_W; l++) begin
            for (int j = 0; j < BIN_POW; j++) begin
                tr_f[l][j] = '0;
                tr_i[l][j] = '0;
            end
        end
        for (int j = 0; j < COUNT_BINS; j++) begin
            tr_f[0][j] = n_hist[j];
            tr_i[0][j] = BIN_W'(j);
        end
        for (int l = 0; l < BIN_W; l++) begin
            for (int j = 0; j < (BIN_POW >> (l + 1)); j++) begin
                if (tr_f[l][2*j+1] > tr_f[l][2*j]) begin
                    tr_f[l+1][j] = tr_f[l][2*j+1];
                    tr_i[l+1][j] = tr_i[l][2*j+1];
                end else begin
                    tr_f[l+1][j] = tr_f[l][2*j];
                    tr_i[l+1][j] = tr_i[l][2*j];
                end
            end
        end
        mode_bin = tr_i[BIN_W][0];
    end

    always_comb begin
        n_collected = r_collected;
        n_idle      = r_idle;
        if (decide) begin
            n_collected = '0;
            n_idle      = '0;
        end else if (qualify) begin
            n_collected = r_collected + WIN_W'(1);
        end else if (r_idle != IDLE_MAX) begin
            n_idle = r_idle + IDLE_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < COUNT_BINS; b++) begin
                r_hist[b] <= '0;
            end
            r_collected <= '0;
            r_idle      <= '0;
        end else if (accept) begin
            for (int b = 0; b < COUNT_BINS; b++) begin
                r_hist[b] <= decide ? '0 : n_hist[b];
            end
            r_collected <= n_collected;
            r_idle      <= n_idle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_decision   <= decide;
            r_decided    <= decide ? COUNT_W'(mode_bin) : '0;
            r_collecting <= qualify;
        end
    end

    assign o_valid          = r_valid;
    assign o_decision_valid = r_decision;
    assign o_decided_count  = r_decided;
    assign o_collecting     = r_collecting;

    a_decision_collects: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_decision |-> r_collecting)
        else $error("decision without a collected frame");

    a_decision_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && decide |=> (r_collected == '0) && (r_idle == '0))
        else $error("counters not cleared after decision");

    a_idle_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !qualify && (r_idle != IDLE_MAX) |=> r_idle == $past(r_idle) + IDLE_W'(1))
        else $error("idle counter did not advance");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_valid)
        else $error("input stalled with empty result register");

endmodule

`default_nettype wire
